### rtl/core/rlpg_pkg.sv
package rlpg_pkg;

    localparam int WORD_W    = 32;
    localparam int DIM_W     = 6;
    localparam int DIM_CNT_W = 7;
    localparam int M_W       = 6;
    localparam int CFG_IDX_W = 8;

    localparam int DEFAULT_MAX_DIMS = 64;

    // command codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_GEN  = 1'b1;

    // ordering modes
    localparam logic ORDER_NATURAL = 1'b0;
    localparam logic ORDER_RADICAL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDERING_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_POINTS   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE   = CFG_IDX_W'(2);

    localparam logic                 RST_ORDERING_MODE = ORDER_RADICAL;
    localparam logic [M_W-1:0]       RST_LOG2_POINTS   = M_W'(20);
    localparam logic [DIM_CNT_W-1:0] RST_DIMS_IN_USE   = DIM_CNT_W'(64);

    // shift amount that makes the fraction the low product word
    localparam logic [M_W-1:0] RADICAL_SHAMT = M_W'(WORD_W);

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] point_index;
        logic [DIM_W-1:0]  entry_dim;
        logic [WORD_W-1:0] entry_generator;
        logic [WORD_W-1:0] entry_shift;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] coordinate;
        logic [DIM_W-1:0]  dim_index;
        logic              last;
    } result_t;

    // one dimension issued into the pipeline
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [DIM_W-1:0]  dim;
        logic [WORD_W-1:0] operand;
        logic [M_W-1:0]    shamt;
    } issue_t;

endpackage

### rtl/core/rlpg_table.sv
module rlpg_table #(
    parameter int MAX_DIMS = rlpg_pkg::DEFAULT_MAX_DIMS,
    parameter int ADDR_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [rlpg_pkg::WORD_W-1:0] wr_gen,
    input  logic [rlpg_pkg::WORD_W-1:0] wr_shift,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [rlpg_pkg::WORD_W-1:0] rd_gen,
    output logic [rlpg_pkg::WORD_W-1:0] rd_shift
);

    logic [2*rlpg_pkg::WORD_W-1:0] mem [MAX_DIMS];
    logic [2*rlpg_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_gen, wr_shift};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_gen   = rd_data_reg[2*rlpg_pkg::WORD_W-1:rlpg_pkg::WORD_W];
    assign rd_shift = rd_data_reg[rlpg_pkg::WORD_W-1:0];

endmodule

### rtl/core/rlpg_seq.sv
module rlpg_seq #(
    parameter int MAX_DIMS = rlpg_pkg::DEFAULT_MAX_DIMS,
    parameter int ADDR_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  rlpg_pkg::cmd_t                 cmd,
    input  logic                           ordering_mode,
    input  logic [rlpg_pkg::M_W-1:0]       log2_points,
    input  logic [rlpg_pkg::DIM_CNT_W-1:0] dims_in_use,
    output logic                           busy,
    output logic                           wr_en,
    output logic [ADDR_W-1:0]              wr_addr,
    output logic [ADDR_W-1:0]              rd_addr,
    output rlpg_pkg::issue_t               issue
);

    localparam logic [rlpg_pkg::DIM_CNT_W-1:0] DIMS_MAX = rlpg_pkg::DIM_CNT_W'(MAX_DIMS);

    logic                           busy_reg, busy_next;
    logic [rlpg_pkg::DIM_CNT_W-1:0] j_reg, j_next;
    logic [rlpg_pkg::DIM_CNT_W-1:0] n_reg, n_next;
    logic [rlpg_pkg::WORD_W-1:0]    operand_reg, operand_next;
    logic [rlpg_pkg::M_W-1:0]       shamt_reg, shamt_next;

    logic                           accept;
    logic [rlpg_pkg::DIM_CNT_W-1:0] n_sat;
    logic [rlpg_pkg::WORD_W-1:0]    k_rev;
    logic                           last_issue;

    assign accept = start && !busy_reg;
    assign n_sat  = (dims_in_use > DIMS_MAX) ? DIMS_MAX : dims_in_use;

    always_comb
    begin
        for (int i = 0; i < rlpg_pkg::WORD_W; i++)
        begin
            k_rev[i] = cmd.point_index[rlpg_pkg::WORD_W-1-i];
        end
    end

    assign last_issue = (j_reg + rlpg_pkg::DIM_CNT_W'(1)) == n_reg;

    // table load on a load transfer; dimensions past the table are dropped
    assign wr_en   = accept && (cmd.func == rlpg_pkg::FUNC_LOAD)
                     && ({1'b0, cmd.entry_dim} < DIMS_MAX);
    assign wr_addr = cmd.entry_dim[ADDR_W-1:0];

    always_comb
    begin
        busy_next    = busy_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        operand_next = operand_reg;
        shamt_next   = shamt_reg;
        if (busy_reg)
        begin
            j_next = j_reg + rlpg_pkg::DIM_CNT_W'(1);
            if (last_issue)
            begin
                busy_next = 1'b0;
            end
        end
        else if (accept && (cmd.func == rlpg_pkg::FUNC_GEN) && (n_sat != '0))
        begin
            busy_next = 1'b1;
            j_next    = '0;
            n_next    = n_sat;
            if (ordering_mode == rlpg_pkg::ORDER_RADICAL)
            begin
                operand_next = k_rev;
                shamt_next   = rlpg_pkg::RADICAL_SHAMT;
            end
            else
            begin
                operand_next = cmd.point_index;
                shamt_next   = log2_points;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            j_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            j_reg    <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        operand_reg <= operand_next;
        shamt_reg   <= shamt_next;
    end

    assign busy          = busy_reg;
    assign rd_addr       = j_reg[ADDR_W-1:0];
    assign issue.valid   = busy_reg;
    assign issue.last    = last_issue;
    assign issue.dim     = j_reg[rlpg_pkg::DIM_W-1:0];
    assign issue.operand = operand_reg;
    assign issue.shamt   = shamt_reg;

endmodule

### rtl/core/rlpg_pipe.sv
module rlpg_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rlpg_pkg::issue_t            issue,
    input  logic [rlpg_pkg::WORD_W-1:0] rd_gen,
    input  logic [rlpg_pkg::WORD_W-1:0] rd_shift,
    output logic                        result_valid,
    output rlpg_pkg::result_t           result
);

    localparam int PROD_W = 2 * rlpg_pkg::WORD_W;
    localparam int WIDE_W = PROD_W + rlpg_pkg::WORD_W;

    // stage 1: lines up with the registered table read
    logic                        s1_valid_reg;
    logic                        s1_last_reg;
    logic [rlpg_pkg::DIM_W-1:0]  s1_dim_reg;
    logic [rlpg_pkg::WORD_W-1:0] s1_operand_reg;
    logic [rlpg_pkg::M_W-1:0]    s1_shamt_reg;

    // stage 2: full product
    logic                        s2_valid_reg;
    logic                        s2_last_reg;
    logic [rlpg_pkg::DIM_W-1:0]  s2_dim_reg;
    logic [rlpg_pkg::M_W-1:0]    s2_shamt_reg;
    logic [PROD_W-1:0]           s2_prod_reg;
    logic [rlpg_pkg::WORD_W-1:0] s2_shift_reg;

    // stage 3: fraction
    logic                        s3_valid_reg;
    logic                        s3_last_reg;
    logic [rlpg_pkg::DIM_W-1:0]  s3_dim_reg;
    logic [rlpg_pkg::WORD_W-1:0] s3_frac_reg, s3_frac_next;
    logic [rlpg_pkg::WORD_W-1:0] s3_shift_reg;

    // stage 4: output register
    logic                        out_valid_reg;
    rlpg_pkg::result_t           out_reg;

    logic [PROD_W-1:0] low_mask;
    logic [WIDE_W-1:0] wide;

    // keep the low m product bits, then read them as m fraction bits truncated to 32
    always_comb
    begin
        low_mask     = ~({PROD_W{1'b1}} << s2_shamt_reg);
        wide         = {s2_prod_reg & low_mask, {rlpg_pkg::WORD_W{1'b0}}} >> s2_shamt_reg;
        s3_frac_next = wide[rlpg_pkg::WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= issue.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg    <= issue.last;
        s1_dim_reg     <= issue.dim;
        s1_operand_reg <= issue.operand;
        s1_shamt_reg   <= issue.shamt;

        s2_last_reg  <= s1_last_reg;
        s2_dim_reg   <= s1_dim_reg;
        s2_shamt_reg <= s1_shamt_reg;
        s2_prod_reg  <= PROD_W'(s1_operand_reg) * PROD_W'(rd_gen);
        s2_shift_reg <= rd_shift;

        s3_last_reg  <= s2_last_reg;
        s3_dim_reg   <= s2_dim_reg;
        s3_frac_reg  <= s3_frac_next;
        s3_shift_reg <= s2_shift_reg;

        out_reg.coordinate <= s3_frac_reg + s3_shift_reg;
        out_reg.dim_index  <= s3_dim_reg;
        out_reg.last       <= s3_last_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/core/rank1_lattice_point_generator_unit.sv
// shifted rank-1 lattice point generator
// command channel: a command transfers on a clock edge with start high and busy low.
//   func load writes one dimension's generator and shift words into the tables,
//   func generate emits one coordinate per dimension in use for point index k.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, write only while idle (0 ordering_mode, 1 log2_points, 2 dims_in_use).
// results: result_valid is high for one cycle per coordinate, dimension order
//   from 0, result.last marks the final coordinate of a point; the receiver
//   cannot stall, so nothing is held back.
// pipeline: each coordinate passes the table read, multiply, fraction select
//   and the shift add into the output register.
// throughput: one coordinate per cycle while a point is issued; busy stays high
//   through a generate with n = min(dims_in_use, MAX_DIMS), the dimension counter
//   issuing one table read per cycle. a load does not set busy.
// reset: rst_n clears the sequencer, pipeline valids and the config registers
//   (radical inverse order, log2_points 20, dims_in_use 64); tables are not
//   cleared and must be loaded before use.
module rank1_lattice_point_generator_unit #(
    parameter int MAX_DIMS = rlpg_pkg::DEFAULT_MAX_DIMS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  rlpg_pkg::cmd_t                 cmd,
    output logic                           busy,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rlpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rlpg_pkg::WORD_W-1:0]    cfg_data,
    output logic                           result_valid,
    output rlpg_pkg::result_t              result
);

    localparam int ADDR_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic                           ordering_mode_reg;
    logic [rlpg_pkg::M_W-1:0]       log2_points_reg;
    logic [rlpg_pkg::DIM_CNT_W-1:0] dims_in_use_reg;

    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [rlpg_pkg::WORD_W-1:0] rd_gen;
    logic [rlpg_pkg::WORD_W-1:0] rd_shift;
    rlpg_pkg::issue_t            issue;

    assign cfg_ready = 1'b1;

    // config transfer; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordering_mode_reg <= rlpg_pkg::RST_ORDERING_MODE;
            log2_points_reg   <= rlpg_pkg::RST_LOG2_POINTS;
            dims_in_use_reg   <= rlpg_pkg::RST_DIMS_IN_USE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rlpg_pkg::REG_ORDERING_MODE: ordering_mode_reg <= cfg_data[0];
                rlpg_pkg::REG_LOG2_POINTS:   log2_points_reg   <= cfg_data[rlpg_pkg::M_W-1:0];
                rlpg_pkg::REG_DIMS_IN_USE:   dims_in_use_reg   <= cfg_data[rlpg_pkg::DIM_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    rlpg_seq #(
        .MAX_DIMS (MAX_DIMS),
        .ADDR_W   (ADDR_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .ordering_mode (ordering_mode_reg),
        .log2_points   (log2_points_reg),
        .dims_in_use   (dims_in_use_reg),
        .busy          (busy),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .issue         (issue)
    );

    rlpg_table #(
        .MAX_DIMS (MAX_DIMS),
        .ADDR_W   (ADDR_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_gen   (cmd.entry_generator),
        .wr_shift (cmd.entry_shift),
        .rd_addr  (rd_addr),
        .rd_gen   (rd_gen),
        .rd_shift (rd_shift)
    );

    rlpg_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .rd_gen       (rd_gen),
        .rd_shift     (rd_shift),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### tb/sv/tb_rank1_lattice_point_generator_unit.sv
module tb_rank1_lattice_point_generator_unit;
    import rlpg_pkg::*;

    localparam int DIMS        = DEFAULT_MAX_DIMS;
    localparam int SETTLE      = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_ITEMS  = 148;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [WORD_W-1:0]     data;
        cmd_t                  c;
        bit                    typed;
        logic [WORD_W-1:0]     coord;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    cmd_t                 cmd;
    logic                 busy;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic                 result_valid;
    result_t              result;

    // predictor state
    logic [WORD_W-1:0]    gen_word [DIMS];
    logic [WORD_W-1:0]    shift_word [DIMS];
    bit                   word_loaded [DIMS];
    logic                 order_mode;
    logic [M_W-1:0]       log2_m;
    logic [DIM_CNT_W-1:0] dims_cfg;

    result_t   coord_q [$];
    stim_row_t stim_rows [$];
    int        mismatches;
    int        quiet_cycles;
    int        burst_left;
    int        rand_items;

    rank1_lattice_point_generator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] lattice_coord(logic [WORD_W-1:0] k,
                                                        logic [WORD_W-1:0] g,
                                                        logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] rev;
        logic [63:0]       prod;
        logic [63:0]       low;
        logic [WORD_W-1:0] frac;
        int                i;
        for (i = 0; i < WORD_W; i++)
            rev[i] = k[WORD_W-1-i];
        if (order_mode == ORDER_RADICAL)
        begin
            prod = {32'd0, rev} * {32'd0, g};
            frac = prod[WORD_W-1:0];
        end
        else
        begin
            prod = {32'd0, k} * {32'd0, g};
            if (log2_m == 0)
                frac = '0;
            else
            begin
                low = prod & ((64'd1 << log2_m) - 64'd1);
                if (log2_m <= 32)
                    frac = WORD_W'(low << (32 - log2_m));
                else
                    frac = WORD_W'(low >> (log2_m - 32));
            end
        end
        return frac + s;
    endfunction

    function automatic int dims_span();
        return (dims_cfg > DIMS) ? DIMS : int'(dims_cfg);
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        stim_row_t r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic stim_row_t load_row(logic [DIM_W-1:0] dim, logic [WORD_W-1:0] g,
                                           logic [WORD_W-1:0] s);
        stim_row_t r;
        r                   = '{default: '0};
        r.c.func            = FUNC_LOAD;
        r.c.point_index     = 32'h5A5A_0F0F;
        r.c.entry_dim       = dim;
        r.c.entry_generator = g;
        r.c.entry_shift     = s;
        return r;
    endfunction

    function automatic stim_row_t gen_row(logic [WORD_W-1:0] k, bit typed = 0,
                                          logic [WORD_W-1:0] coord = '0);
        stim_row_t r;
        r                   = '{default: '0};
        r.c.func            = FUNC_GEN;
        r.c.point_index     = k;
        r.c.entry_dim       = DIM_W'(k);
        r.c.entry_generator = ~k;
        r.c.entry_shift     = k ^ 32'h3C3C_3C3C;
        r.typed             = typed;
        r.coord             = coord;
        return r;
    endfunction

    // start is left high on return so that back-to-back transfers keep it up
    task automatic send_cmd(cmd_t c, bit typed = 0, logic [WORD_W-1:0] coord = '0);
        int      gap;
        int      j;
        int      span;
        result_t r;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        if (c.func == FUNC_LOAD)
        begin
            gen_word[c.entry_dim]    = c.entry_generator;
            shift_word[c.entry_dim]  = c.entry_shift;
            word_loaded[c.entry_dim] = 1'b1;
        end
        else if (typed)
        begin
            r.coordinate = coord;
            r.dim_index  = '0;
            r.last       = 1'b1;
            coord_q.push_back(r);
        end
        else
        begin
            span = dims_span();
            for (j = 0; j < span; j++)
            begin
                r.coordinate = lattice_coord(c.point_index, gen_word[j], shift_word[j]);
                r.dim_index  = DIM_W'(j);
                r.last       = (j == span - 1);
                coord_q.push_back(r);
            end
        end
    endtask

    // drop start, drain expected coordinates, then let loads and empty points settle
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (coord_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ORDERING_MODE: order_mode = data[0];
            REG_LOG2_POINTS:   log2_m     = data[M_W-1:0];
            REG_DIMS_IN_USE:   dims_cfg   = data[DIM_CNT_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checking and the no-progress watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (result_valid)
            begin
                if (coord_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected coordinate %h dim %0d last %0d",
                                 result.coordinate, result.dim_index, result.last);
                end
                else
                begin
                    want = coord_q.pop_front();
                    if (result.coordinate !== want.coordinate
                        || result.dim_index !== want.dim_index
                        || result.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("coordinate exp %h dim %0d last %0d, got %h dim %0d last %0d",
                                     want.coordinate, want.dim_index, want.last,
                                     result.coordinate, result.dim_index, result.last);
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("rank1_lattice_point_generator_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t         row;
        cmd_t              c;
        int                j;
        int                n;
        int                span;
        int                pick;
        logic [WORD_W-1:0] v;

        start        = 1'b0;
        cmd          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        rand_items   = 0;
        order_mode   = RST_ORDERING_MODE;
        log2_m       = RST_LOG2_POINTS;
        dims_cfg     = RST_DIMS_IN_USE;
        for (j = 0; j < DIMS; j++)
        begin
            gen_word[j]    = '0;
            shift_word[j]  = '0;
            word_loaded[j] = 1'b0;
        end

        // directed part: extremes of every field, both orderings and the corner registers
        stim_rows.push_back(cfg_row(REG_DIMS_IN_USE, 1));
        stim_rows.push_back(load_row(0, 32'h1234_5678, 32'hDEAD_BEEF));
        stim_rows.push_back(gen_row(32'h0000_0000, 1, 32'hDEAD_BEEF));
        stim_rows.push_back(gen_row(32'hFFFF_FFFF));
        stim_rows.push_back(load_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        stim_rows.push_back(gen_row(32'h0000_0001, 1, 32'h7FFF_FFFF));
        stim_rows.push_back(gen_row(32'h8000_0000, 1, 32'hFFFF_FFFE));
        stim_rows.push_back(load_row(1, 32'h9E37_79B9, 32'h0000_0000));
        stim_rows.push_back(load_row(2, 32'h0000_0001, 32'h8000_0000));
        stim_rows.push_back(load_row(3, 32'h7FFF_FFFF, 32'h0000_0001));
        stim_rows.push_back(load_row(63, 32'h0000_0000, 32'h0000_0000));
        stim_rows.push_back(cfg_row(REG_DIMS_IN_USE, 4));
        stim_rows.push_back(gen_row(32'h0000_0001));
        stim_rows.push_back(gen_row(32'hA5A5_5A5A));
        stim_rows.push_back(cfg_row(REG_ORDERING_MODE, ORDER_NATURAL));
        stim_rows.push_back(cfg_row(REG_LOG2_POINTS, 32));
        stim_rows.push_back(gen_row(32'hFFFF_FFFF));
        stim_rows.push_back(gen_row(32'h0000_0003));
        stim_rows.push_back(cfg_row(REG_LOG2_POINTS, 1));
        stim_rows.push_back(gen_row(32'h0000_0005));
        // zero log2 points: coordinate is the shift word
        stim_rows.push_back(cfg_row(REG_LOG2_POINTS, 0));
        stim_rows.push_back(cfg_row(REG_DIMS_IN_USE, 1));
        stim_rows.push_back(gen_row(32'h1234_5678, 1, 32'hFFFF_FFFF));
        stim_rows.push_back(cfg_row(REG_DIMS_IN_USE, 4));
        stim_rows.push_back(cfg_row(REG_LOG2_POINTS, 63));
        stim_rows.push_back(gen_row(32'hFFFF_FFFF));
        stim_rows.push_back(cfg_row(REG_LOG2_POINTS, 20));
        stim_rows.push_back(gen_row(32'h000F_FFFF));
        stim_rows.push_back(gen_row(32'h0010_0000));
        // no dimensions in use: the point produces nothing
        stim_rows.push_back(cfg_row(REG_DIMS_IN_USE, 0));
        stim_rows.push_back(gen_row(32'h0000_0007));
        stim_rows.push_back(cfg_row(8'd3, 32'h0000_0005));
        stim_rows.push_back(cfg_row(8'd255, 32'h0000_0000));
        stim_rows.push_back(cfg_row(REG_DIMS_IN_USE, 2));
        stim_rows.push_back(gen_row(32'h5555_5555));
        stim_rows.push_back(cfg_row(REG_ORDERING_MODE, ORDER_RADICAL));
        stim_rows.push_back(gen_row(32'hAAAA_AAAA));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.is_cfg)
            begin
                wait_idle();
                write_reg(row.idx, row.data);
            end
            else
                send_cmd(row.c, row.typed, row.coord);
        end

        // random part: register settings change between bursts of points and loads
        while (rand_items < RAND_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 1) == 0)
            begin
                v = $urandom_range(0, 1);
                if ($urandom_range(0, 3) == 0)
                    v = v | ($urandom << 1);
                write_reg(REG_ORDERING_MODE, v);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = 32;
                    3:       v = $urandom_range(33, 62);
                    4:       v = 63;
                    default: v = $urandom_range(1, 32);
                endcase
                if ($urandom_range(0, 3) == 0)
                    v = v | ($urandom << M_W);
                write_reg(REG_LOG2_POINTS, v);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 11))
                    0:       v = 0;
                    1:       v = 64;
                    2:       v = 127;
                    3:       v = $urandom_range(65, 126);
                    4:       v = $urandom_range(9, 63);
                    default: v = $urandom_range(1, 8);
                endcase
                if ($urandom_range(0, 3) == 0)
                    v = v | ($urandom << DIM_CNT_W);
                write_reg(REG_DIMS_IN_USE, v);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(3, 255)), $urandom);

            n = $urandom_range(4, 16);
            repeat (n)
            begin
                c.point_index     = $urandom;
                c.entry_dim       = $urandom;
                c.entry_generator = $urandom;
                c.entry_shift     = $urandom;
                if ($urandom_range(0, 9) < 3)
                begin
                    c.func = FUNC_LOAD;
                    if ($urandom_range(0, 1) == 0)
                        c.entry_dim = $urandom_range(0, 7);
                    if ($urandom_range(0, 5) == 0)
                        c.entry_generator = ($urandom_range(0, 1) == 0) ? '0 : '1;
                    if ($urandom_range(0, 5) == 0)
                        c.entry_shift = ($urandom_range(0, 1) == 0) ? '0 : '1;
                end
                else
                begin
                    c.func = FUNC_GEN;
                    // every entry read by the point must have been loaded
                    span = dims_span();
                    for (j = 0; j < span; j++)
                    begin
                        if (!word_loaded[j])
                        begin
                            cmd_t fill;
                            fill.func            = FUNC_LOAD;
                            fill.point_index     = $urandom;
                            fill.entry_dim       = DIM_W'(j);
                            fill.entry_generator = $urandom;
                            fill.entry_shift     = $urandom;
                            send_cmd(fill);
                            rand_items++;
                        end
                    end
                    pick = $urandom_range(0, 6);
                    case (pick)
                        0: c.point_index = '0;
                        1: c.point_index = '1;
                        2: c.point_index = $urandom_range(0, 255);
                        3: c.point_index = $urandom & ((32'd1 << $urandom_range(1, 31)) - 1);
                        default: ;
                    endcase
                end
                send_cmd(c);
                rand_items++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (coord_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE + 4) @(posedge clk);

        if (mismatches == 0 && coord_q.size() == 0)
            $display("rank1_lattice_point_generator_unit: match");
        else
            $display("rank1_lattice_point_generator_unit: mismatch");
        $finish;
    end

endmodule
